// ===== rtl/core/bssc_pkg.sv =====
// Shared types and constants for the bounded step sequence counter.
`default_nettype none

package bssc_pkg;

    localparam int COUNT_W = 30;
    localparam int ENTRY_W = 8;
    localparam int CFG_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

    // Control state of the top-level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUM  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Control bundle broadcast to every cell.
    typedef struct packed {
        logic step;   // apply one sequence element
        logic start;  // element is the first of its sequence
        logic shift;  // move counts one cell toward cell 0
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bssc_entry_if.sv =====
// Input channel carrying one sequence element per item.
`default_nettype none

interface bssc_entry_if;
    logic                         valid;
    logic                         ready;
    logic [bssc_pkg::ENTRY_W-1:0] entry_value;
    logic                         last_entry;

    modport source (output valid, output entry_value, output last_entry, input ready);
    modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bssc_result_if.sv =====
// Output channel carrying one sequence count per item.
`default_nettype none

interface bssc_result_if;
    logic                         valid;
    logic                         ready;
    logic [bssc_pkg::COUNT_W-1:0] sequence_count;

    modport source (output valid, output sequence_count, input ready);
    modport sink   (input valid, input sequence_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bounded_step_sequence_counter.sv =====
// Top level of the bounded step sequence counter: cell row and sum sequencer.
//
//   channel  | dir | payload                           | handshake
//   ---------+-----+-----------------------------------+-------------------
//   entry    | in  | entry_value[7:0], last_entry      | valid/ready
//   result   | out | sequence_count[29:0]              | valid/ready
//   cfg      | in  | cfg_wdata[7:0] -> max_value       | cfg_we, no stall
//
// An element that is not last updates every cell at once from its own count
// and its two neighbors. A last element first updates the cells; then the
// counts of all MAX_VALUES cells shift down the cell row into a modular
// accumulator at cell 0, and then the result register is loaded.
// entry.ready is low during the sum; a result still waiting for result.ready
// holds the block in the load step, but new elements may be taken while an
// earlier result sits in the output register. Reset sets max_value to 128,
// clears all counts and marks the next element as the first of a sequence.
`default_nettype none

module bounded_step_sequence_counter #(
    parameter int MAX_VALUES = 128
) (
    input  wire                          clk,
    input  wire                          rst_n,
    bssc_entry_if.sink                   entry,
    bssc_result_if.source                result,
    input  wire                          cfg_we,
    input  wire  [bssc_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int VAL_BITS = $clog2(MAX_VALUES + 1);
    localparam int VAL_W    = (VAL_BITS > bssc_pkg::CFG_W) ? VAL_BITS : bssc_pkg::CFG_W;
    localparam int CNT_W    = $clog2(MAX_VALUES);
    localparam int CW       = bssc_pkg::COUNT_W;

    bssc_pkg::state_t     state_reg, state_next;
    bssc_pkg::cell_ctrl_t ctrl;

    logic [bssc_pkg::CFG_W-1:0] max_value_reg;
    logic                       start_reg;
    logic [CNT_W-1:0]           sum_cnt_reg, sum_cnt_next;
    logic [CW-1:0]              acc_reg, acc_next;
    logic                       out_valid_reg;
    logic [CW-1:0]              out_data_reg;

    logic [VAL_W-1:0] bound;
    logic [VAL_W-1:0] max_ext;
    logic [VAL_W-1:0] entry_ext;
    logic             accept;
    logic             load_out;
    logic [CW:0]      acc_sum;

    // Neighbor nets of the cell row; gated index 0 and MAX_VALUES+1 and raw index MAX_VALUES are the zero edges.
    logic [CW-1:0] gated  [0:MAX_VALUES+1];
    logic [CW-1:0] raw    [0:MAX_VALUES];

    // Effective bound: max_value saturated to the cell count.
    assign max_ext   = VAL_W'(max_value_reg);
    assign bound     = (max_ext > VAL_W'(MAX_VALUES)) ? VAL_W'(MAX_VALUES) : max_ext;
    assign entry_ext = VAL_W'(entry.entry_value);

    assign entry.ready = (state_reg == bssc_pkg::ST_IDLE);
    assign accept      = entry.valid && entry.ready;

    assign ctrl.step  = accept;
    assign ctrl.start = start_reg;
    assign ctrl.shift = (state_reg == bssc_pkg::ST_SUM);

    assign gated[0]            = '0;
    assign gated[MAX_VALUES+1] = '0;
    assign raw[MAX_VALUES]     = '0;

    for (genvar i = 0; i < MAX_VALUES; i++)
    begin : g_cell
        bssc_cell #(
            .IDX   (i),
            .VAL_W (VAL_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .entry_ext (entry_ext),
            .bound     (bound),
            .left_in   (gated[i]),
            .right_in  (gated[i+2]),
            .shift_in  (raw[i+1]),
            .gated_out (gated[i+1]),
            .count_out (raw[i])
        );
    end

    // Accumulator: both terms below mod, one conditional subtract.
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, raw[0]};
    assign load_out = (state_reg == bssc_pkg::ST_EMIT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next   = state_reg;
        sum_cnt_next = sum_cnt_reg;
        acc_next     = acc_reg;
        case (state_reg)
            bssc_pkg::ST_IDLE:
            begin
                if (accept && entry.last_entry)
                begin
                    state_next   = bssc_pkg::ST_SUM;
                    sum_cnt_next = CNT_W'(MAX_VALUES - 1);
                    acc_next     = '0;
                end
            end
            bssc_pkg::ST_SUM:
            begin
                acc_next = (acc_sum >= {1'b0, bssc_pkg::COUNT_MOD})
                         ? CW'(acc_sum - {1'b0, bssc_pkg::COUNT_MOD})
                         : acc_sum[CW-1:0];
                if (sum_cnt_reg == '0)
                    state_next = bssc_pkg::ST_EMIT;
                else
                    sum_cnt_next = sum_cnt_reg - 1'b1;
            end
            bssc_pkg::ST_EMIT:
            begin
                if (load_out)
                    state_next = bssc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bssc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bssc_pkg::ST_IDLE;
            max_value_reg <= bssc_pkg::CFG_W'(128);
            start_reg     <= 1'b1;
            sum_cnt_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_cnt_reg <= sum_cnt_next;
            acc_reg     <= acc_next;
            if (cfg_we)
                max_value_reg <= cfg_wdata;
            if (accept)
                start_reg <= entry.last_entry;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= acc_reg;
    end

    assign result.valid          = out_valid_reg;
    assign result.sequence_count = out_data_reg;

    // Sum phase runs exactly down to zero, then hands off to the load step.
    a_sum_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bssc_pkg::ST_SUM && sum_cnt_reg == '0) |=> state_reg == bssc_pkg::ST_EMIT)
        else $error("sum phase did not end in load step");

    // A result appears only out of the load step.
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bssc_pkg::ST_EMIT))
        else $error("result valid rose outside load step");

    // Accumulator stays reduced.
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg < bssc_pkg::COUNT_MOD)
        else $error("accumulator out of range");

    // Taking a last element starts the sum and marks a fresh sequence.
    a_last_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && entry.last_entry) |=> (start_reg && state_reg == bssc_pkg::ST_SUM))
        else $error("last element did not start the sum");

endmodule

`default_nettype wire

// ===== rtl/core/bssc_cell.sv =====
// One count cell: holds the count for a single value and talks to its neighbors.
`default_nettype none

module bssc_cell #(
    parameter int IDX   = 0,
    parameter int VAL_W = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire bssc_pkg::cell_ctrl_t    ctrl,
    input  wire  [VAL_W-1:0]             entry_ext,
    input  wire  [VAL_W-1:0]             bound,
    input  wire  [bssc_pkg::COUNT_W-1:0] left_in,    // gated count of value-1
    input  wire  [bssc_pkg::COUNT_W-1:0] right_in,   // gated count of value+1
    input  wire  [bssc_pkg::COUNT_W-1:0] shift_in,   // raw count of next cell
    output logic [bssc_pkg::COUNT_W-1:0] gated_out,
    output logic [bssc_pkg::COUNT_W-1:0] count_out
);

    localparam logic [VAL_W-1:0] MY_VAL = VAL_W'(IDX + 1);

    logic [bssc_pkg::COUNT_W-1:0] count_reg;
    logic [bssc_pkg::COUNT_W-1:0] count_next;
    logic                         in_range;
    logic                         allowed;
    logic [bssc_pkg::COUNT_W+1:0] sum3;
    logic [bssc_pkg::COUNT_W+1:0] red1;
    logic [bssc_pkg::COUNT_W+1:0] red2;
    logic [bssc_pkg::COUNT_W+1:0] mod_ext;

    assign in_range  = (MY_VAL <= bound);
    assign allowed   = in_range && ((entry_ext == '0) || (entry_ext == MY_VAL));
    assign gated_out = in_range ? count_reg : '0;
    assign count_out = count_reg;

    // Sum is below 3*mod: two conditional subtracts bring it into range.
    assign mod_ext = {2'b00, bssc_pkg::COUNT_MOD};
    assign sum3    = {2'b00, left_in} + {2'b00, gated_out} + {2'b00, right_in};
    assign red1    = (sum3 >= mod_ext) ? (sum3 - mod_ext) : sum3;
    assign red2    = (red1 >= mod_ext) ? (red1 - mod_ext) : red1;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.step)
        begin
            if (!allowed)
                count_next = '0;
            else if (ctrl.start)
                count_next = bssc_pkg::COUNT_W'(1);
            else
                count_next = red2[bssc_pkg::COUNT_W-1:0];
        end
        else if (ctrl.shift)
        begin
            count_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_bounded_step_sequence_counter.sv =====
// Self-checking testbench for the bounded step sequence counter.
module tb_bounded_step_sequence_counter;

    localparam int MAX_VALUES    = 128;
    localparam int RANDOM_ITEMS  = 1050;
    // A last item costs an update, the shifts of all MAX_VALUES cells and a load.
    localparam int SUM_CYCLES    = MAX_VALUES + 2;
    localparam int SETTLE_CYCLES = SUM_CYCLES + 10;
    // Longest correct quiet stretch is a sum, an output stall and a settle
    // pause before a register write; this is several times that.
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 23;
    localparam int CALM_FIRST    = 400;
    localparam int CALM_LAST     = 650;

    typedef enum logic {ROW_ENTRY, ROW_CFG} row_kind_t;

    // One row of the directed table. A pinned row carries its count typed in;
    // other last rows are checked against the count model.
    typedef struct packed {
        row_kind_t                    kind;
        logic [bssc_pkg::ENTRY_W-1:0] value;
        logic                         last;
        logic                         pinned;
        logic [bssc_pkg::COUNT_W-1:0] count;
    } stim_row_t;

    typedef struct packed {
        logic                         pinned;
        logic [bssc_pkg::COUNT_W-1:0] count;
    } count_pin_t;

    localparam int NUM_ROWS = 27;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // single elements right after reset, bound 128
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b1, 30'd128}, // free: every value allowed
        '{ROW_ENTRY, 8'd1,   1'b1, 1'b1, 30'd1},   // lowest fixed value
        '{ROW_ENTRY, 8'd128, 1'b1, 1'b1, 30'd1},   // highest fixed value
        '{ROW_ENTRY, 8'd129, 1'b1, 1'b1, 30'd0},   // just above the bound
        '{ROW_ENTRY, 8'd255, 1'b1, 1'b1, 30'd0},   // all ones
        // two free elements, then a short walk
        '{ROW_ENTRY, 8'd0,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd5,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd6,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b0, 30'd0},
        // neighbors two apart: no sequence survives
        '{ROW_ENTRY, 8'd5,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd7,   1'b1, 1'b1, 30'd0},
        // zero bound allows nothing
        '{ROW_CFG,   8'd0,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b1, 30'd0},
        // bound of one: only the all-ones sequence
        '{ROW_CFG,   8'd1,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b1, 30'd1},
        // bound above capacity saturates
        '{ROW_CFG,   8'd255, 1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b1, 30'd128},
        // bound shrinks in the middle of a sequence
        '{ROW_CFG,   8'd3,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b0, 1'b0, 30'd0},
        '{ROW_CFG,   8'd2,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b1, 1'b0, 30'd0},
        // top edge of the cell row
        '{ROW_CFG,   8'd128, 1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd128, 1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd0,   1'b0, 1'b0, 30'd0},
        '{ROW_ENTRY, 8'd127, 1'b1, 1'b0, 30'd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [bssc_pkg::CFG_W-1:0] cfg_wdata;
    logic                       calm;       // no idling on either side while set
    int                         mismatches = 0;

    bssc_entry_if  entry_ch();
    bssc_result_if result_ch();

    bounded_step_sequence_counter #(.MAX_VALUES(MAX_VALUES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (entry_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Count model. Cells 0 and MAX_VALUES+1 are padding and stay zero, so
    // the neighbor sums need no edge cases.
    // ------------------------------------------------------------------
    logic [bssc_pkg::COUNT_W-1:0] value_counts [0:MAX_VALUES+1];
    logic                         at_start;
    logic [bssc_pkg::CFG_W-1:0]   max_value_model;

    count_pin_t                   count_pins [$];  // one per last item sent, in order
    logic [bssc_pkg::COUNT_W-1:0] due_counts [$];  // sequence counts not yet seen

    // Applies one element; returns 1 with the sequence total on a last one.
    function automatic logic advance_counts(input logic [bssc_pkg::ENTRY_W-1:0] fixed,
                                            input logic closing,
                                            output logic [bssc_pkg::COUNT_W-1:0] total);
        logic [bssc_pkg::COUNT_W-1:0] prev [0:MAX_VALUES+1];
        int unsigned                  bound;
        longint unsigned              acc;
        bound = (max_value_model > MAX_VALUES) ? MAX_VALUES : max_value_model;
        // counts above the current bound read as zero
        for (int v = 0; v <= MAX_VALUES + 1; v++)
            prev[v] = (v >= 1 && v <= bound) ? value_counts[v] : '0;
        for (int v = 1; v <= MAX_VALUES; v++)
        begin
            if (v <= bound && (fixed == 0 || fixed == v))
            begin
                if (at_start)
                    value_counts[v] = bssc_pkg::COUNT_W'(1);
                else
                begin
                    acc = 64'(prev[v-1]) + 64'(prev[v]) + 64'(prev[v+1]);
                    value_counts[v] = bssc_pkg::COUNT_W'(acc % 64'(bssc_pkg::COUNT_MOD));
                end
            end
            else
                value_counts[v] = '0;
        end
        total = '0;
        if (!closing)
        begin
            at_start = 1'b0;
            return 1'b0;
        end
        acc = 0;
        for (int v = 1; v <= MAX_VALUES; v++)
            acc = (acc + 64'(value_counts[v])) % 64'(bssc_pkg::COUNT_MOD);
        total = bssc_pkg::COUNT_W'(acc);
        at_start = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [bssc_pkg::COUNT_W-1:0] got,
                                   input logic [bssc_pkg::COUNT_W-1:0] want);
        $display("mismatch at %0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels and the register port at each rising
    // edge, before any of this edge's updates land. Also the watchdog.
    // ------------------------------------------------------------------
    int stall_cycles;

    always @(posedge clk)
    begin : monitor
        logic [bssc_pkg::COUNT_W-1:0] total;
        logic [bssc_pkg::COUNT_W-1:0] want;
        count_pin_t                   pin;
        logic                         moved;
        if (!rst_n)
        begin
            for (int v = 0; v <= MAX_VALUES + 1; v++)
                value_counts[v] = '0;
            at_start        = 1'b1;
            max_value_model = bssc_pkg::CFG_W'(128);
            stall_cycles    = 0;
        end
        else
        begin
            moved = 1'b0;
            if (entry_ch.valid && entry_ch.ready)
            begin
                moved = 1'b1;
                if (advance_counts(entry_ch.entry_value, entry_ch.last_entry, total))
                begin
                    pin = count_pins.pop_front();
                    due_counts.push_back(pin.pinned ? pin.count : total);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                moved = 1'b1;
                if (due_counts.size() == 0)
                    report_mismatch("count with no sequence pending",
                                    result_ch.sequence_count, '0);
                else
                begin
                    want = due_counts.pop_front();
                    if (result_ch.sequence_count !== want)
                        report_mismatch("sequence_count", result_ch.sequence_count, want);
                end
            end
            // a write here applies from the next element on
            if (cfg_we)
                max_value_model = cfg_wdata;
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles with no item moving", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, none during the calm stretch.
    always @(posedge clk)
        result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Driver tasks. Each is entered at the edge that took the previous item
    // (or a write), so valid gets one assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_entry(input logic [bssc_pkg::ENTRY_W-1:0] value, input logic last,
                              input logic pinned,
                              input logic [bssc_pkg::COUNT_W-1:0] count);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            entry_ch.valid <= 1'b0;
            @(posedge clk);
        end
        entry_ch.valid       <= 1'b1;
        entry_ch.entry_value <= value;
        entry_ch.last_entry  <= last;
        if (last)
            count_pins.push_back('{pinned, count});
        do
            @(posedge clk);
        while (!entry_ch.ready);
    endtask

    // Writes max_value once the block has gone quiet: no count pending and
    // enough cycles for any element still in the cell row to settle.
    task automatic write_max_value(input logic [bssc_pkg::CFG_W-1:0] value);
        entry_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Bounds for the random part: extremes often, anything else sometimes.
    function automatic logic [bssc_pkg::CFG_W-1:0] pick_bound();
        case ($urandom_range(9))
            0: return bssc_pkg::CFG_W'(0);
            1: return bssc_pkg::CFG_W'(1);
            2: return bssc_pkg::CFG_W'(2);
            3: return bssc_pkg::CFG_W'(127);
            4: return bssc_pkg::CFG_W'(128);
            5: return bssc_pkg::CFG_W'(255);
            default: return bssc_pkg::CFG_W'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly well-formed sequences: free entries and fixed entries that walk
    // by at most one, so counts stay alive and wrap the modulus. A few
    // entries are arbitrary bytes, which usually break the sequence.
    task automatic run_random_sequences();
        int                           sent;
        int                           seq_len;
        int                           walker;
        int                           cap;
        int                           pick;
        logic [bssc_pkg::ENTRY_W-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= CALM_FIRST && sent < CALM_LAST);
            if ($urandom_range(99) < 15)
                write_max_value(pick_bound());
            seq_len = ($urandom_range(99) < 10) ? $urandom_range(41, 160)
                                                : $urandom_range(1, 40);
            walker = $urandom_range(1, MAX_VALUES);
            for (int i = 0; i < seq_len; i++)
            begin
                // rare bound change between two elements of a sequence
                if (i > 0 && $urandom_range(99) < 2)
                    write_max_value(pick_bound());
                cap = (max_value_model > MAX_VALUES) ? MAX_VALUES : max_value_model;
                if (cap < 1)
                    cap = 1;
                pick = $urandom_range(99);
                if (pick < 50)
                    value = '0;
                else if (pick < 94)
                begin
                    walker = walker + int'($urandom_range(0, 2)) - 1;
                    if (walker > cap)
                        walker = cap;
                    if (walker < 1)
                        walker = 1;
                    value = bssc_pkg::ENTRY_W'(walker);
                end
                else
                    value = bssc_pkg::ENTRY_W'($urandom_range(0, 255));
                send_entry(value, i == seq_len - 1, 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random sequences, drain.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        calm                 = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        entry_ch.valid       = 1'b0;
        entry_ch.entry_value = '0;
        entry_ch.last_entry  = 1'b0;
        result_ch.ready      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_max_value(DIRECTED[r].value);
            else
                send_entry(DIRECTED[r].value, DIRECTED[r].last,
                           DIRECTED[r].pinned, DIRECTED[r].count);
        end

        run_random_sequences();

        // drain: wait for every count, then watch for strays
        entry_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
